@@ rtl/core/vgpc_pkg.sv @@
// Shared types and constants for the velocity gain and peak calibration block.
// Holds the request/result structs, the control state enum and the fixed-point constants.
// Used by vgpc_serial_mul, vgpc_serial_div and velocity_gain_peak_calibrate.
`default_nettype none

package vgpc_pkg;

    localparam int VEL_FRAC_BITS = 15;
    localparam int VEL_W         = 16;
    localparam int GAIN_W        = 16;
    localparam int MUL_W         = 16;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int GAIN1_FRAC    = 12;
    localparam int GAIN2_FRAC    = 13;

    localparam logic [63:0] VEL_ONE = 64'd1 << VEL_FRAC_BITS;
    localparam logic [PROD_W-1:0] VEL_LIMIT =
        (VEL_ONE > 64'd65535) ? PROD_W'(65535) : PROD_W'(VEL_ONE);

    // The divisor must hold the quarter value even for wide fraction settings.
    localparam int DVS_W = (VEL_FRAC_BITS - 1 > GAIN_W) ? VEL_FRAC_BITS - 1 : GAIN_W;
    localparam logic [DVS_W-1:0] VEL_QUARTER = DVS_W'(VEL_ONE >> 2);

    // Reciprocal numerator is 1.0 in velocity format shifted into Q3.13.
    localparam logic [63:0] RECIP_NUM = VEL_ONE << GAIN2_FRAC;
    localparam logic [DVS_W-1:0] DIV_REM_INIT = DVS_W'(RECIP_NUM >> GAIN_W);
    localparam logic [GAIN_W-1:0] DIV_LOW_BITS = RECIP_NUM[GAIN_W-1:0];

    localparam logic [GAIN_W-1:0] FIXED_GAIN_RESET = 16'd4096;
    localparam logic [GAIN_W-1:0] RECIP_RESET      = 16'd8192;
    localparam logic [GAIN_W-1:0] RECIP_MAX        = 16'd32768;

    localparam logic OP_HAMMER = 1'b0;
    localparam logic OP_DAMPER = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [VEL_W-1:0] velocity_in;
        logic             key_event;
        logic             peak_switch;
        logic             frame_start;
    } vgpc_req_t;

    typedef struct packed {
        logic [VEL_W-1:0] velocity_out;
        logic             was_clamped;
    } vgpc_res_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] mcand;
        logic [MUL_W-1:0] mplier;
    } vgpc_mul_req_t;

    typedef struct packed {
        logic             start;
        logic [DVS_W-1:0] divisor;
    } vgpc_div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } vgpc_state_t;

endpackage

`default_nettype wire

@@ rtl/core/vgpc_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on vgpc_pkg for widths and the start request struct.
`default_nettype none

module vgpc_serial_mul
    import vgpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vgpc_mul_req_t      mreq,
    output logic                    done,
    output logic [PROD_W-1:0]       product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MUL_W-1:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MUL_W:0]    sum;

    // The low half holds the remaining multiplier bits; the high half accumulates.
    assign sum = {1'b0, prod_reg[PROD_W-1:MUL_W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        if (mreq.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(MUL_W - 1);
            mcand_next = mreq.mcand;
            prod_next  = {{MUL_W{1'b0}}, mreq.mplier};
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[MUL_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

@@ rtl/core/vgpc_serial_div.sv @@
// Restoring divider producing the Q3.13 reciprocal gain, one quotient bit per cycle.
// Depends on vgpc_pkg for the numerator constants and the start request struct.
`default_nettype none

module vgpc_serial_div
    import vgpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vgpc_div_req_t      dreq,
    output logic                    done,
    output logic [GAIN_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(GAIN_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [GAIN_W-1:0] sh_reg, sh_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W+1:0]  diff;
    logic              fits;

    // The upper numerator bits start below the divisor, so only the low
    // numerator bits are shifted through; they leave as quotient bits enter.
    assign trial = {rem_reg, sh_reg[GAIN_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = !diff[DVS_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (dreq.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(GAIN_W - 1);
            dvs_next  = dreq.divisor;
            rem_next  = DIV_REM_INIT;
            sh_next   = DIV_LOW_BITS;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            sh_next  = {sh_reg[GAIN_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

@@ rtl/core/velocity_gain_peak_calibrate.sv @@
// Key velocity scaling with fixed gain, peak calibration and reciprocal gain.
// Depends on vgpc_pkg, vgpc_serial_mul and vgpc_serial_div.
//
// Usage:
//   A request on req_valid/req_ready carries one key item; one result leaves on
//   res_valid/res_ready for every request, in order. The user must write the fixed
//   gain through cfg_we/cfg_wdata only while no request is in flight; the block
//   itself does not enforce this. One request is worked on at a time; req_ready
//   is high only while idle. A single bit-serial multiplier does both scaling
//   stages, and a bit-serial divider forms the reciprocal when a hammer
//   frame-start item sees the calibration switch released with a peak found.
//   The next request is taken the cycle after the result is registered.
//   Reset clears the switch history and the peak, loads a reciprocal of 1.0
//   and a fixed gain of 1.0. A stalled receiver holds the result in the
//   output register; a new request is still accepted, and its own result
//   waits until the output register is free.
`default_nettype none

module velocity_gain_peak_calibrate
    import vgpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire vgpc_req_t         req_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output vgpc_res_t              res_data,
    input  wire logic              cfg_we,
    input  wire logic [GAIN_W-1:0] cfg_wdata
);

    vgpc_state_t       state_reg, state_next;
    vgpc_req_t         item_reg, item_next;
    logic [GAIN_W-1:0] fixed_gain_reg, fixed_gain_next;
    logic              prev_sw_reg, prev_sw_next;
    logic              peak_found_reg, peak_found_next;
    logic              tracking_reg, tracking_next;
    logic [VEL_W-1:0]  peak_reg, peak_next;
    logic [GAIN_W-1:0] recip_reg, recip_next;
    logic [VEL_W-1:0]  vel_reg, vel_next;
    logic              flag_reg, flag_next;
    logic              res_valid_reg, res_valid_next;
    vgpc_res_t         res_reg, res_next;

    vgpc_mul_req_t     mreq;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;
    vgpc_div_req_t     dreq;
    logic              div_done;
    logic [GAIN_W-1:0] div_quot;

    logic [PROD_W-1:0] sh1, sh2;
    logic              clamp1, clamp2;
    logic [VEL_W-1:0]  p1, p2;
    logic [DVS_W-1:0]  peak_wide, divisor_now;
    logic              scale_go;
    vgpc_req_t         scale_item;
    logic              rise, fall;

    vgpc_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .done    (mul_done),
        .product (mul_product)
    );

    vgpc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .dreq     (dreq),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sh1    = mul_product >> GAIN1_FRAC;
    assign sh2    = mul_product >> GAIN2_FRAC;
    assign clamp1 = sh1 > VEL_LIMIT;
    assign clamp2 = sh2 > VEL_LIMIT;
    assign p1     = clamp1 ? VEL_LIMIT[VEL_W-1:0] : sh1[VEL_W-1:0];
    assign p2     = clamp2 ? VEL_LIMIT[VEL_W-1:0] : sh2[VEL_W-1:0];

    assign peak_wide   = DVS_W'(peak_reg);
    assign divisor_now = (peak_wide < VEL_QUARTER) ? VEL_QUARTER : peak_wide;

    assign rise = req_data.peak_switch && !prev_sw_reg;
    assign fall = !req_data.peak_switch && prev_sw_reg;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        fixed_gain_next = fixed_gain_reg;
        prev_sw_next    = prev_sw_reg;
        peak_found_next = peak_found_reg;
        tracking_next   = tracking_reg;
        peak_next       = peak_reg;
        recip_next      = recip_reg;
        vel_next        = vel_reg;
        flag_next       = flag_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        mreq            = '0;
        dreq            = '0;
        scale_go        = 1'b0;
        scale_item      = item_reg;

        if (cfg_we)
        begin
            fixed_gain_next = cfg_wdata;
        end

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req_data;
                    vel_next   = req_data.velocity_in;
                    flag_next  = 1'b0;
                    scale_item = req_data;
                    scale_go   = 1'b1;
                    if (req_data.opcode == OP_HAMMER && req_data.frame_start)
                    begin
                        if (rise)
                        begin
                            peak_found_next = 1'b0;
                            peak_next       = '0;
                        end
                        tracking_next = req_data.peak_switch && prev_sw_reg;
                        prev_sw_next  = req_data.peak_switch;
                        // The reciprocal must be ready before this item's scaling.
                        if (fall && peak_found_reg)
                        begin
                            dreq.start   = 1'b1;
                            dreq.divisor = divisor_now;
                            scale_go     = 1'b0;
                            state_next   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    recip_next = div_quot;
                    scale_go   = 1'b1;
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    vel_next  = p1;
                    flag_next = clamp1;
                    if (item_reg.opcode == OP_DAMPER)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (tracking_reg && p1 > peak_reg)
                        begin
                            peak_next       = p1;
                            peak_found_next = 1'b1;
                        end
                        mreq.start  = 1'b1;
                        mreq.mcand  = p1;
                        mreq.mplier = recip_reg;
                        state_next  = ST_MUL2;
                    end
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    vel_next   = p2;
                    flag_next  = flag_reg || clamp2;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.velocity_out = vel_reg;
                    res_next.was_clamped  = flag_reg;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scale_go)
        begin
            if (scale_item.key_event)
            begin
                mreq.start  = 1'b1;
                mreq.mcand  = scale_item.velocity_in;
                mreq.mplier = fixed_gain_reg;
                state_next  = ST_MUL1;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fixed_gain_reg <= FIXED_GAIN_RESET;
            prev_sw_reg    <= 1'b0;
            peak_found_reg <= 1'b0;
            tracking_reg   <= 1'b0;
            peak_reg       <= '0;
            recip_reg      <= RECIP_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fixed_gain_reg <= fixed_gain_next;
            prev_sw_reg    <= prev_sw_next;
            peak_found_reg <= peak_found_next;
            tracking_reg   <= tracking_next;
            peak_reg       <= peak_next;
            recip_reg      <= recip_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        vel_reg  <= vel_next;
        flag_reg <= flag_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL1 || state_reg == ST_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        recip_reg <= RECIP_MAX)
        else $error("reciprocal gain above its maximum");

    a_peak_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_reg != '0) |-> peak_found_reg)
        else $error("nonzero peak without peak found");

    a_clamped_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.was_clamped && !$past(res_valid_reg))
            |-> (res_reg.velocity_out == VEL_LIMIT[VEL_W-1:0]))
        else $error("clamped result not at the limit");

endmodule

`default_nettype wire
